// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/ist_pkg.sv
// types and codes of the integer set table
package ist_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic                     full_reject;
    logic [CountW-1:0]        count;
    logic                     is_empty;
    logic signed [ValueW-1:0] min_value;
    logic signed [ValueW-1:0] max_value;
  } rsp_t;

endpackage

// File: rtl/core/integer_set_table_unit.sv
// integer set table: compact entry memory with one search, shift and min/max pass
// a word is accepted only in the idle state; busy stays high through the scan and finish
//   states, so no new word is taken before the last one has passed FINISH
// the entry memory is walked once per word through its single read port; the result strobe
//   is registered from the FINISH state and the receiver cannot stall
// reset empties the set; entry memory contents are not cleared
module integer_set_table_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ist_pkg::req_t req_i,
  output logic          done_o,
  output ist_pkg::rsp_t rsp_o
);
  import ist_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_e                   state_q, state_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     rvld_q, rvld_d;
  logic [AW-1:0]            ridx_q;
  logic                     found_q, found_d;
  logic                     have_q, have_d;
  logic signed [ValueW-1:0] min_q, min_d;
  logic signed [ValueW-1:0] max_q, max_d;
  logic [1:0]               op_q, op_d;
  logic signed [ValueW-1:0] val_q, val_d;
  rsp_t                     rsp_q, rsp_d;
  logic                     done_q, done_d;

  logic signed [ValueW-1:0] mem [CAPACITY];
  logic signed [ValueW-1:0] rdata_q;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [ValueW-1:0] wdata;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      have_q  <= have_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
    op_q  <= op_d;
    val_q <= val_d;
    rsp_q <= rsp_d;
    if (re) begin
      ridx_q <= raddr;
    end
  end

  always_comb begin
    logic                     hit;
    logic                     full;
    logic                     incl;
    logic [CW-1:0]            ncnt;
    logic signed [ValueW-1:0] lo;
    logic signed [ValueW-1:0] hi;

    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    rvld_d  = 1'b0;
    found_d = found_q;
    have_d  = have_q;
    min_d   = min_q;
    max_d   = max_q;
    op_d    = op_q;
    val_d   = val_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    re      = 1'b0;
    raddr   = ptr_q[AW-1:0];
    we      = 1'b0;
    waddr   = ridx_q - AW'(1);
    wdata   = rdata_q;
    hit     = 1'b0;
    full    = 1'b0;
    incl    = 1'b0;
    ncnt    = cnt_q;
    lo      = '0;
    hi      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = req_i.operation;
          val_d   = req_i.value;
          ptr_d   = '0;
          found_d = 1'b0;
          have_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr_q < cnt_q) begin
          re     = 1'b1;
          ptr_d  = ptr_q + CW'(1);
          rvld_d = 1'b1;
        end
        if (rvld_q) begin
          if (rdata_q == val_q) begin
            found_d = 1'b1;
          end else begin
            have_d = 1'b1;
            if (!have_q || rdata_q < min_q) begin
              min_d = rdata_q;
            end
            if (!have_q || rdata_q > max_q) begin
              max_d = rdata_q;
            end
            // close the gap behind a removed entry
            if (found_q && op_q == OP_REMOVE) begin
              we = 1'b1;
            end
          end
        end
        if (ptr_q == cnt_q && !rvld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        case (op_q)
          OP_INSERT: begin
            if (found_q) begin
              incl = 1'b1;
            end else if (cnt_q >= CapCount) begin
              full = 1'b1;
            end else begin
              hit   = 1'b1;
              incl  = 1'b1;
              ncnt  = cnt_q + CW'(1);
              we    = 1'b1;
              waddr = cnt_q[AW-1:0];
              wdata = val_q;
            end
          end
          OP_REMOVE: begin
            if (found_q) begin
              hit  = 1'b1;
              ncnt = cnt_q - CW'(1);
            end
          end
          OP_QUERY: begin
            hit  = found_q;
            incl = found_q;
          end
          default: begin
            incl = found_q;
          end
        endcase
        if (incl) begin
          lo = (have_q && min_q < val_q) ? min_q : val_q;
          hi = (have_q && max_q > val_q) ? max_q : val_q;
        end else if (have_q) begin
          lo = min_q;
          hi = max_q;
        end
        cnt_d             = ncnt;
        rsp_d.hit         = hit;
        rsp_d.full_reject = full;
        rsp_d.count       = CountW'(ncnt);
        rsp_d.is_empty    = (ncnt == '0);
        rsp_d.min_value   = lo;
        rsp_d.max_value   = hi;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CapCount)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_IMPLIES(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_IMPLIES(a_hit_full, clk_i, rst_ni, done_o, !(rsp_o.hit && rsp_o.full_reject))
  `ASSERT_IMPLIES(a_shift_remove, clk_i, rst_ni, we && state_q == ST_SCAN, op_q == OP_REMOVE)

endmodule
